>>> rtl/cssv_pkg.sv
// Package for the CSS color token validator.
// Holds the word types, status codes, pattern states and code point constants.
// No dependencies.
package cssv_pkg;

    // Longest string that is decoded; longer strings are flagged as too long.
    localparam int MAX_LEN = 4096;
    // Byte counter and span width: holds MAX_LEN + 1.
    localparam int CNT_W   = 13;

    // Code points with a special role.
    localparam logic [20:0] CP_KELVIN    = 21'h212a;
    localparam logic [20:0] CP_LONG_S    = 21'h017f;
    localparam logic [20:0] CP_NBSP      = 21'h00a0;
    localparam logic [20:0] CP_OGHAM     = 21'h1680;
    localparam logic [20:0] CP_EN_QUAD   = 21'h2000;
    localparam logic [20:0] CP_HAIR      = 21'h200a;
    localparam logic [20:0] CP_LINE_SEP  = 21'h2028;
    localparam logic [20:0] CP_PARA_SEP  = 21'h2029;
    localparam logic [20:0] CP_NNBSP     = 21'h202f;
    localparam logic [20:0] CP_MMSP      = 21'h205f;
    localparam logic [20:0] CP_IDEO_SP   = 21'h3000;
    localparam logic [20:0] CP_BOM       = 21'hfeff;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_UTF8  = 3'd1,
        ST_BLANK     = 3'd2,
        ST_NON_ASCII = 3'd3,
        ST_MISMATCH  = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        PS_START = 5'd0,
        PS_HASH  = 5'd1,
        PS_WORD  = 5'd2,
        PS_R     = 5'd3,
        PS_RG    = 5'd4,
        PS_RGB   = 5'd5,
        PS_RGBA  = 5'd6,
        PS_H     = 5'd7,
        PS_HS    = 5'd8,
        PS_HSL   = 5'd9,
        PS_HSLA  = 5'd10,
        PS_OPEN  = 5'd11,
        PS_BODY  = 5'd12,
        PS_CLOSE = 5'd13,
        PS_DEAD  = 5'd14
    } t_pat_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } t_in_word;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] span_start;
        logic [CNT_W-1:0] span_end;
    } t_out_word;

endpackage

>>> rtl/css_color_token_validator.sv
// CSS color token validator, top level.
// Depends on cssv_pkg for word types, status codes and pattern states.
//
// Usage: a string enters one byte per word on the input channel
// (i_in_valid / o_in_stall / i_in_word). A word with byte_present low
// carries no byte; with last high it still ends the string, so an empty
// string is one such word. The word marked last produces one result word
// on the output channel (o_out_valid / i_out_stall / o_out_word): a status,
// and on acceptance the trimmed byte span. Other words produce nothing.
//
// Throughput is one byte per cycle while no last word waits on a full
// output register. A word is held in the input register while the UTF-8
// decoder and pattern matcher update the per-string state; the result word
// is registered in the output register when the last word is processed.
// Per-string state clears after each last word.
//
// While the output register holds a result that the receiver stalls, the
// bytes of the next string keep flowing; only a further last word waits,
// and it stalls the input channel until the output register is free.
// Synchronous reset empties both registers and clears the string state.
module css_color_token_validator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cssv_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cssv_pkg::t_out_word  o_out_word
);

    localparam int W = cssv_pkg::CNT_W;

    // Input and output registers.
    logic                r_in_valid;
    cssv_pkg::t_in_word  r_in;
    logic                r_out_valid;
    cssv_pkg::t_out_word r_out;

    // Per-string state.
    logic [W-1:0]         r_count,  n_count;
    logic [20:0]          r_partial, n_partial;
    logic [1:0]           r_cont,   n_cont;
    logic [W-1:0]         r_char_start, n_char_start;
    logic                 r_content, n_content;
    logic [W-1:0]         r_first,  n_first;
    logic [W-1:0]         r_end,    n_end;
    cssv_pkg::t_pat_state r_pat,    n_pat;
    logic [3:0]           r_hex,    n_hex;
    logic                 r_acc,    n_acc;
    logic                 r_bad,    n_bad;
    logic                 r_nonascii, n_nonascii;

    logic         out_free;
    logic         proc;
    logic         char_valid;
    logic [20:0]  char_code;
    logic [W-1:0] char_end;
    logic [W-1:0] char_first;
    logic         is_space;
    logic         content_char;
    logic         space_feed;
    logic [20:0]  folded;
    logic         non_ascii;
    logic         feed_valid;
    logic [6:0]   feed_char;
    logic         dead_evt;
    logic         pat_acc;
    logic         is_letter;
    logic         is_hex;
    logic         is_body;
    cssv_pkg::t_pat_state letter_nx;
    cssv_pkg::t_status    status;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign proc        = r_in_valid && (!r_in.last || out_free);
    assign o_in_stall  = r_in_valid && !proc;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // UTF-8 decode and byte counting.
    always_comb begin
        n_count      = r_count;
        n_partial    = r_partial;
        n_cont       = r_cont;
        n_char_start = r_char_start;
        n_bad        = r_bad;
        char_valid   = 1'b0;
        char_code    = '0;
        char_end     = '0;
        char_first   = r_char_start;
        if (r_in.byte_present) begin
            if (r_count == W'(cssv_pkg::MAX_LEN)) begin
                n_count = W'(cssv_pkg::MAX_LEN + 1);
            end else if (r_count < W'(cssv_pkg::MAX_LEN)) begin
                n_count = r_count + 1'b1;
                if (!r_bad) begin
                    if (r_cont != 2'd0) begin
                        if (r_in.data_byte[7:6] != 2'b10) begin
                            n_bad  = 1'b1;
                            n_cont = 2'd0;
                        end else begin
                            n_partial = {r_partial[14:0], r_in.data_byte[5:0]};
                            n_cont    = r_cont - 2'd1;
                            if (r_cont == 2'd1) begin
                                char_valid = 1'b1;
                                char_code  = n_partial;
                                char_end   = n_count;
                            end
                        end
                    end else begin
                        n_char_start = r_count;
                        char_first   = r_count;
                        if (!r_in.data_byte[7]) begin
                            char_valid = 1'b1;
                            char_code  = {13'd0, r_in.data_byte};
                            char_end   = n_count;
                        end else if (r_in.data_byte inside {[8'hc2:8'hdf]}) begin
                            n_partial = {16'd0, r_in.data_byte[4:0]};
                            n_cont    = 2'd1;
                        end else if (r_in.data_byte inside {[8'he0:8'hef]}) begin
                            n_partial = {17'd0, r_in.data_byte[3:0]};
                            n_cont    = 2'd2;
                        end else if (r_in.data_byte inside {[8'hf0:8'hf4]}) begin
                            n_partial = {18'd0, r_in.data_byte[2:0]};
                            n_cont    = 2'd3;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Character classification, trimming and case folding.
    always_comb begin
        is_space = char_code inside {[21'h9:21'hd], 21'h20, cssv_pkg::CP_NBSP,
            cssv_pkg::CP_OGHAM, [cssv_pkg::CP_EN_QUAD:cssv_pkg::CP_HAIR],
            cssv_pkg::CP_LINE_SEP, cssv_pkg::CP_PARA_SEP, cssv_pkg::CP_NNBSP,
            cssv_pkg::CP_MMSP, cssv_pkg::CP_IDEO_SP, cssv_pkg::CP_BOM};
        content_char = char_valid && !is_space;
        space_feed   = char_valid && is_space && r_content;

        if (char_code == cssv_pkg::CP_KELVIN) begin
            folded = 21'h6b;
        end else if (char_code == cssv_pkg::CP_LONG_S) begin
            folded = 21'h73;
        end else if (char_code inside {[21'h41:21'h5a]}) begin
            folded = char_code | 21'h20;
        end else begin
            folded = char_code;
        end
        non_ascii = folded > 21'h7f;

        dead_evt   = content_char && non_ascii;
        feed_valid = space_feed || (content_char && !non_ascii);
        feed_char  = space_feed ? 7'h20 : folded[6:0];

        n_content  = r_content;
        n_first    = r_first;
        n_end      = r_end;
        n_nonascii = r_nonascii;
        if (content_char) begin
            n_content = 1'b1;
            n_end     = char_end;
            if (!r_content) begin
                n_first = char_first;
            end
        end
        if (dead_evt) begin
            n_nonascii = 1'b1;
        end
    end

    // Pattern matcher: next state.
    always_comb begin
        is_letter = feed_char inside {[7'h61:7'h7a]};
        is_hex    = feed_char inside {[7'h30:7'h39], [7'h61:7'h66]};
        is_body   = feed_char inside {[7'h30:7'h39], 7'h2e, 7'h2c, 7'h25, 7'h2b,
                                      7'h2d, 7'h20};
        case (r_pat)
            cssv_pkg::PS_START: letter_nx = (feed_char == 7'h72) ? cssv_pkg::PS_R :
                                            (feed_char == 7'h68) ? cssv_pkg::PS_H :
                                            cssv_pkg::PS_WORD;
            cssv_pkg::PS_R:   letter_nx = (feed_char == 7'h67) ? cssv_pkg::PS_RG :
                                          cssv_pkg::PS_WORD;
            cssv_pkg::PS_RG:  letter_nx = (feed_char == 7'h62) ? cssv_pkg::PS_RGB :
                                          cssv_pkg::PS_WORD;
            cssv_pkg::PS_RGB: letter_nx = (feed_char == 7'h61) ? cssv_pkg::PS_RGBA :
                                          cssv_pkg::PS_WORD;
            cssv_pkg::PS_H:   letter_nx = (feed_char == 7'h73) ? cssv_pkg::PS_HS :
                                          cssv_pkg::PS_WORD;
            cssv_pkg::PS_HS:  letter_nx = (feed_char == 7'h6c) ? cssv_pkg::PS_HSL :
                                          cssv_pkg::PS_WORD;
            cssv_pkg::PS_HSL: letter_nx = (feed_char == 7'h61) ? cssv_pkg::PS_HSLA :
                                          cssv_pkg::PS_WORD;
            default:          letter_nx = cssv_pkg::PS_WORD;
        endcase

        n_pat = r_pat;
        n_hex = r_hex;
        if (dead_evt) begin
            n_pat = cssv_pkg::PS_DEAD;
        end else if (feed_valid) begin
            n_pat = cssv_pkg::PS_DEAD;
            case (r_pat)
                cssv_pkg::PS_START: begin
                    if (feed_char == 7'h23) begin
                        n_pat = cssv_pkg::PS_HASH;
                    end else if (is_letter) begin
                        n_pat = letter_nx;
                    end
                end
                cssv_pkg::PS_HASH: begin
                    if (is_hex && r_hex < 4'd8) begin
                        n_hex = r_hex + 4'd1;
                        n_pat = cssv_pkg::PS_HASH;
                    end
                end
                cssv_pkg::PS_WORD, cssv_pkg::PS_R, cssv_pkg::PS_RG, cssv_pkg::PS_RGB,
                cssv_pkg::PS_RGBA, cssv_pkg::PS_H, cssv_pkg::PS_HS, cssv_pkg::PS_HSL,
                cssv_pkg::PS_HSLA: begin
                    if (is_letter) begin
                        n_pat = letter_nx;
                    end else if (feed_char == 7'h28 && (r_pat inside {cssv_pkg::PS_RGB,
                            cssv_pkg::PS_RGBA, cssv_pkg::PS_HSL, cssv_pkg::PS_HSLA})) begin
                        n_pat = cssv_pkg::PS_OPEN;
                    end
                end
                cssv_pkg::PS_OPEN, cssv_pkg::PS_BODY: begin
                    if (is_body) begin
                        n_pat = cssv_pkg::PS_BODY;
                    end else if (feed_char == 7'h29 && r_pat == cssv_pkg::PS_BODY) begin
                        n_pat = cssv_pkg::PS_CLOSE;
                    end
                end
                default: n_pat = cssv_pkg::PS_DEAD;
            endcase
        end
    end

    // Pattern matcher: acceptance after the latest visible character.
    always_comb begin
        if (n_pat == cssv_pkg::PS_HASH) begin
            pat_acc = (n_hex >= 4'd3) && (n_hex <= 4'd8);
        end else begin
            pat_acc = n_pat inside {[cssv_pkg::PS_WORD:cssv_pkg::PS_HSLA], cssv_pkg::PS_CLOSE};
        end
        n_acc = content_char ? pat_acc : r_acc;
    end

    // Verdict in priority order.
    always_comb begin
        if (n_count > W'(cssv_pkg::MAX_LEN)) begin
            status = cssv_pkg::ST_TOO_LONG;
        end else if (n_bad || n_cont != 2'd0) begin
            status = cssv_pkg::ST_BAD_UTF8;
        end else if (!n_content) begin
            status = cssv_pkg::ST_BLANK;
        end else if (n_nonascii) begin
            status = cssv_pkg::ST_NON_ASCII;
        end else if (!n_acc) begin
            status = cssv_pkg::ST_MISMATCH;
        end else begin
            status = cssv_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_in_valid || proc) begin
                r_in_valid <= i_in_valid;
            end
            if (proc && r_in.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_in_valid || proc) && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (proc && r_in.last) begin
            r_out.status     <= status;
            r_out.span_start <= (status == cssv_pkg::ST_OK) ? n_first : '0;
            r_out.span_end   <= (status == cssv_pkg::ST_OK) ? n_end : '0;
        end
    end

    // String state; cleared by reset and after each last word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_in.last)) begin
            r_count      <= '0;
            r_partial    <= '0;
            r_cont       <= 2'd0;
            r_char_start <= '0;
            r_content    <= 1'b0;
            r_first      <= '0;
            r_end        <= '0;
            r_pat        <= cssv_pkg::PS_START;
            r_hex        <= 4'd0;
            r_acc        <= 1'b0;
            r_bad        <= 1'b0;
            r_nonascii   <= 1'b0;
        end else if (proc) begin
            r_count      <= n_count;
            r_partial    <= n_partial;
            r_cont       <= n_cont;
            r_char_start <= n_char_start;
            r_content    <= n_content;
            r_first      <= n_first;
            r_end        <= n_end;
            r_pat        <= n_pat;
            r_hex        <= n_hex;
            r_acc        <= n_acc;
            r_bad        <= n_bad;
            r_nonascii   <= n_nonascii;
        end
    end

endmodule

>>> rtl/cssv_checker.sv
// Port-level checks for the CSS color token validator.
// Depends on cssv_pkg; bound to css_color_token_validator below.
module cssv_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input cssv_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cssv_pkg::t_out_word o_out_word
);

    // Reset leaves no result word behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // A stalled input word is held by the sender.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("stalled input word changed");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // Rejected strings carry an empty span.
    a_reject_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != cssv_pkg::ST_OK |->
            o_out_word.span_start == '0 && o_out_word.span_end == '0)
        else $error("span reported on a rejected string");

    // An accepted span is non-empty and within the length limit.
    a_ok_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == cssv_pkg::ST_OK |->
            o_out_word.span_start < o_out_word.span_end &&
            o_out_word.span_end <= cssv_pkg::CNT_W'(cssv_pkg::MAX_LEN))
        else $error("accepted span out of order or out of range");

endmodule

bind css_color_token_validator cssv_checker u_cssv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
